// ----- rtl/elr_pkg.sv -----
`default_nettype none
package elr_pkg;

    localparam int unsigned CoordW  = 10;
    localparam int unsigned AxisW   = 9;
    localparam int unsigned PointW  = 12;
    localparam int unsigned SqW     = 2 * AxisW;
    localparam int unsigned LinW    = SqW + CoordW;
    localparam int unsigned MulAW   = LinW;
    localparam int unsigned MulBW   = SqW;
    localparam int unsigned ProdW   = MulAW + MulBW;
    localparam int unsigned AccW    = LinW + CoordW + 2;
    localparam int unsigned IdxW    = 2;

    localparam logic [CoordW-1:0] XyMax = 10'd1023;

    localparam logic [IdxW-1:0] REG_CENTER_X    = 2'd0;
    localparam logic [IdxW-1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [IdxW-1:0] REG_SEMI_AXIS_A = 2'd2;
    localparam logic [IdxW-1:0] REG_SEMI_AXIS_B = 2'd3;

    typedef struct packed {
        logic [CoordW-1:0] center_x;
        logic [CoordW-1:0] center_y;
        logic [AxisW-1:0]  semi_axis_a;
        logic [AxisW-1:0]  semi_axis_b;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AA,
        S_BB,
        S_BX,
        S_AY,
        S_CMP,
        S_D1,
        S_D2,
        S_D3,
        S_D4
    } state_t;

    function automatic logic [PointW-1:0] pt_add(input logic [CoordW-1:0] c,
                                                 input logic [CoordW-1:0] d);
        pt_add = {2'b00, c} + {2'b00, d};
    endfunction

    function automatic logic [PointW-1:0] pt_sub(input logic [CoordW-1:0] c,
                                                 input logic [CoordW-1:0] d);
        pt_sub = {2'b00, c} - {2'b00, d};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/elr_if.sv -----
`default_nettype none
interface elr_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface elr_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] q1_x;
    logic signed [11:0] q1_y;
    logic signed [11:0] q4_x;
    logic signed [11:0] q4_y;
    logic signed [11:0] q3_x;
    logic signed [11:0] q3_y;
    logic signed [11:0] q2_x;
    logic signed [11:0] q2_y;
    logic              point_valid;
    logic              done_res;
    modport source (output valid, output q1_x, output q1_y, output q4_x, output q4_y,
                    output q3_x, output q3_y, output q2_x, output q2_y,
                    output point_valid, output done_res, input ready);
    modport sink (input valid, input q1_x, input q1_y, input q4_x, input q4_y,
                  input q3_x, input q3_y, input q2_x, input q2_y,
                  input point_valid, input done_res, output ready);
endinterface

interface elr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/elr_cfg_regs.sv -----
`default_nettype none
module elr_cfg_regs (
    input  wire logic  clk,
    input  wire logic  rst_n,
    elr_cfg_if.sink    cfg,
    output elr_pkg::cfg_t regs
);
    import elr_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER_X:    regs_next.center_x    = cfg.data;
                REG_CENTER_Y:    regs_next.center_y    = cfg.data;
                REG_SEMI_AXIS_A: regs_next.semi_axis_a = cfg.data[AxisW-1:0];
                REG_SEMI_AXIS_B: regs_next.semi_axis_b = cfg.data[AxisW-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.center_x    <= 10'd400;
            regs_reg.center_y    <= 10'd400;
            regs_reg.semi_axis_a <= 9'd100;
            regs_reg.semi_axis_b <= 9'd50;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/elr_mul.sv -----
`default_nettype none
module elr_mul (
    input  wire logic                        clk,
    input  wire logic [elr_pkg::MulAW-1:0]   op_a,
    input  wire logic [elr_pkg::MulBW-1:0]   op_b,
    output logic      [elr_pkg::ProdW-1:0]   prod
);
    import elr_pkg::*;

    logic [ProdW-1:0] prod_reg;
    logic [ProdW-1:0] prod_next;

    assign prod_next = {{MulBW{1'b0}}, op_a} * {{MulAW{1'b0}}, op_b};
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule
`default_nettype wire

// ----- rtl/ellipse_region1_rasterizer_core.sv -----
// Channel | Dir | Handshake     | Word
// req     | in  | valid/ready   | restart
// rsp     | out | valid/ready   | q1..q4 x/y, point_valid, done_res
// cfg     | in  | valid/ready   | index, data (always ready)
//
// One step word runs S_AA, S_BB, S_BX, S_AY and S_CMP, and goes on through S_D1 to S_D4
// when it tests the implicit value; all products go through one registered multiplier.
// Reset (rst_n, async low) sets the config defaults and an idle walk.
// req is ready only in idle; a result held in rsp stalls the step in its
// compare cycle until rsp is free.
`default_nettype none
module ellipse_region1_rasterizer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    elr_req_if.sink   req,
    elr_rsp_if.source rsp,
    elr_cfg_if.sink   cfg
);
    import elr_pkg::*;

    cfg_t regs;

    state_t state_reg, state_next;
    logic [CoordW-1:0] x_reg, x_next;
    logic [CoordW-1:0] y_reg, y_next;
    logic              active_reg, active_next;
    logic [SqW-1:0]    aa_reg, aa_next;
    logic [SqW-1:0]    bb_reg, bb_next;
    logic [LinW-1:0]   bx_reg, bx_next;
    logic [LinW-1:0]   ay_reg, ay_next;
    logic signed [AccW-1:0] acc_reg, acc_next;

    logic              ov_reg, ov_next;
    logic [PointW-1:0] q1x_reg, q1y_reg, q4x_reg, q4y_reg;
    logic [PointW-1:0] q3x_reg, q3y_reg, q2x_reg, q2y_reg;
    logic [PointW-1:0] q1x_next, q1y_next, q4x_next, q4y_next;
    logic [PointW-1:0] q3x_next, q3y_next, q2x_next, q2y_next;
    logic              pv_reg, pv_next, dn_reg, dn_next;

    logic [MulAW-1:0]  op_a;
    logic [MulBW-1:0]  op_b;
    logic [ProdW-1:0]  prod;
    logic [LinW:0]     bx_inc;
    logic signed [AccW-1:0] di;
    logic              out_free;

    elr_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg), .regs(regs));
    elr_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.q1_x        = q1x_reg;
    assign rsp.q1_y        = q1y_reg;
    assign rsp.q4_x        = q4x_reg;
    assign rsp.q4_y        = q4y_reg;
    assign rsp.q3_x        = q3x_reg;
    assign rsp.q3_y        = q3y_reg;
    assign rsp.q2_x        = q2x_reg;
    assign rsp.q2_y        = q2y_reg;
    assign rsp.point_valid = pv_reg;
    assign rsp.done_res    = dn_reg;

    assign out_free = !ov_reg || rsp.ready;
    assign bx_inc   = {1'b0, bx_reg} + {{(LinW+1-SqW){1'b0}}, bb_reg};
    assign di       = acc_reg - $signed(prod[AccW-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        active_next = active_reg;
        aa_next     = aa_reg;
        bb_next     = bb_reg;
        bx_next     = bx_reg;
        ay_next     = ay_reg;
        acc_next    = acc_reg;
        ov_next     = ov_reg && !rsp.ready;
        q1x_next = q1x_reg; q1y_next = q1y_reg; q4x_next = q4x_reg; q4y_next = q4y_reg;
        q3x_next = q3x_reg; q3y_next = q3y_reg; q2x_next = q2x_reg; q2y_next = q2y_reg;
        pv_next     = pv_reg;
        dn_next     = dn_reg;
        // aa * y by default; held through the compare stall
        op_a = {{(MulAW-SqW){1'b0}}, aa_reg};
        op_b = {{(MulBW-CoordW){1'b0}}, y_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.restart)
                    begin
                        x_next      = '0;
                        y_next      = {1'b0, regs.semi_axis_b};
                        active_next = 1'b1;
                    end
                    state_next = S_AA;
                end
            end
            S_AA:
            begin
                op_a       = {{(MulAW-AxisW){1'b0}}, regs.semi_axis_a};
                op_b       = {{(MulBW-AxisW){1'b0}}, regs.semi_axis_a};
                state_next = S_BB;
            end
            S_BB:
            begin
                op_a       = {{(MulAW-AxisW){1'b0}}, regs.semi_axis_b};
                op_b       = {{(MulBW-AxisW){1'b0}}, regs.semi_axis_b};
                aa_next    = prod[SqW-1:0];
                state_next = S_BX;
            end
            S_BX:
            begin
                op_a       = {{(MulAW-CoordW){1'b0}}, x_reg};
                op_b       = prod[SqW-1:0];
                bb_next    = prod[SqW-1:0];
                state_next = S_AY;
            end
            S_AY:
            begin
                bx_next    = prod[LinW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    q1x_next = '0; q1y_next = '0; q4x_next = '0; q4y_next = '0;
                    q3x_next = '0; q3y_next = '0; q2x_next = '0; q2y_next = '0;
                    state_next = S_IDLE;
                    if (!active_reg || (bx_reg > prod[LinW-1:0]))
                    begin
                        active_next = 1'b0;
                        pv_next     = 1'b0;
                        dn_next     = 1'b1;
                    end
                    else
                    begin
                        pv_next  = 1'b1;
                        dn_next  = 1'b0;
                        q1x_next = pt_add(regs.center_x, x_reg);
                        q1y_next = pt_add(regs.center_y, y_reg);
                        q4x_next = pt_add(regs.center_x, x_reg);
                        q4y_next = pt_sub(regs.center_y, y_reg);
                        q3x_next = pt_sub(regs.center_x, x_reg);
                        q3y_next = pt_sub(regs.center_y, y_reg);
                        q2x_next = pt_sub(regs.center_x, x_reg);
                        q2y_next = pt_add(regs.center_y, y_reg);
                        if (x_reg >= XyMax)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            x_next  = x_reg + 1'b1;
                            bx_next = bx_inc[LinW-1:0];
                            ay_next = prod[LinW-1:0];
                            if (bx_inc < {1'b0, prod[LinW-1:0]})
                                state_next = S_D1;
                        end
                    end
                end
            end
            S_D1:
            begin
                op_a       = bx_reg;
                op_b       = {{(MulBW-CoordW){1'b0}}, x_reg};
                state_next = S_D2;
            end
            S_D2:
            begin
                acc_next   = $signed(prod[AccW-1:0]);
                op_a       = ay_reg;
                op_b       = {{(MulBW-CoordW){1'b0}}, y_reg};
                state_next = S_D3;
            end
            S_D3:
            begin
                acc_next   = acc_reg + $signed(prod[AccW-1:0]);
                op_a       = {{(MulAW-SqW){1'b0}}, aa_reg};
                op_b       = bb_reg;
                state_next = S_D4;
            end
            S_D4:
            begin
                if (!di[AccW-1] && (y_reg != '0))
                    y_next = y_reg - 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg  <= aa_next;
        bb_reg  <= bb_next;
        bx_reg  <= bx_next;
        ay_reg  <= ay_next;
        acc_reg <= acc_next;
        q1x_reg <= q1x_next;
        q1y_reg <= q1y_next;
        q4x_reg <= q4x_next;
        q4y_reg <= q4y_next;
        q3x_reg <= q3x_next;
        q3y_reg <= q3y_next;
        q2x_reg <= q2x_next;
        q2y_reg <= q2y_next;
        pv_reg  <= pv_next;
        dn_reg  <= dn_next;
    end
endmodule
`default_nettype wire

// ----- rtl/elr_checker.sv -----
`default_nettype none
module elr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [95:0] rsp_points,
    input wire logic        rsp_point_valid,
    input wire logic        rsp_done_res
);
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_point_valid != rsp_done_res))
        else $error("point_valid and done_res not exclusive");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_done_res) |-> (rsp_points == '0))
        else $error("done word carries nonzero points");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready right after accepting a word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_points)))
        else $error("stalled rsp word changed");
endmodule

bind ellipse_region1_rasterizer_core elr_checker u_elr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_points      ({rsp.q1_x, rsp.q1_y, rsp.q4_x, rsp.q4_y,
                       rsp.q3_x, rsp.q3_y, rsp.q2_x, rsp.q2_y}),
    .rsp_point_valid (rsp.point_valid),
    .rsp_done_res    (rsp.done_res)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

typedef logic [9:0][11:0] raster_word_t;

class ellipse_walk_checker;
    localparam int ValidF = 8;
    localparam int DoneF  = 9;

    logic [9:0] ctr_x;
    logic [9:0] ctr_y;
    logic [8:0] axis_a;
    logic [8:0] axis_b;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    bit         walking;

    raster_word_t expected_points[$];
    int           error_count;
    string        field_names[10] = '{"q1_x", "q1_y", "q4_x", "q4_y", "q3_x", "q3_y",
                                      "q2_x", "q2_y", "point_valid", "done_res"};

    function new();
        ctr_x       = 10'd400;
        ctr_y       = 10'd400;
        axis_a      = 9'd100;
        axis_b      = 9'd50;
        pos_x       = '0;
        pos_y       = '0;
        walking     = 1'b0;
        error_count = 0;
    endfunction

    function void set_reg(logic [elr_pkg::IdxW-1:0] idx, logic [9:0] val);
        case (idx)
            elr_pkg::REG_CENTER_X:    ctr_x  = val;
            elr_pkg::REG_CENTER_Y:    ctr_y  = val;
            elr_pkg::REG_SEMI_AXIS_A: axis_a = val[8:0];
            elr_pkg::REG_SEMI_AXIS_B: axis_b = val[8:0];
            default: ;
        endcase
    endfunction

    function int outstanding();
        return expected_points.size();
    endfunction

    function void predict_step(bit restart);
        raster_word_t      w;
        longint unsigned   aa;
        longint unsigned   bb;
        longint            di_val;
        w  = '0;
        aa = 64'(axis_a) * 64'(axis_a);
        bb = 64'(axis_b) * 64'(axis_b);
        if (restart)
        begin
            pos_x   = '0;
            pos_y   = {1'b0, axis_b};
            walking = 1'b1;
        end
        if (!walking || bb * pos_x > aa * pos_y)
        begin
            walking  = 1'b0;
            w[DoneF] = 12'd1;
        end
        else
        begin
            w[0] = 12'(ctr_x) + 12'(pos_x);
            w[1] = 12'(ctr_y) + 12'(pos_y);
            w[2] = 12'(ctr_x) + 12'(pos_x);
            w[3] = 12'(ctr_y) - 12'(pos_y);
            w[4] = 12'(ctr_x) - 12'(pos_x);
            w[5] = 12'(ctr_y) - 12'(pos_y);
            w[6] = 12'(ctr_x) - 12'(pos_x);
            w[7] = 12'(ctr_y) + 12'(pos_y);
            w[ValidF] = 12'd1;
            if (pos_x == elr_pkg::XyMax)
            begin
                walking = 1'b0;
            end
            else
            begin
                pos_x = pos_x + 10'd1;
                if (bb * pos_x < aa * pos_y)
                begin
                    di_val = longint'(bb * pos_x * pos_x + aa * pos_y * pos_y)
                             - longint'(aa * bb);
                    if (di_val >= 0 && pos_y != 10'd0)
                        pos_y = pos_y - 10'd1;
                end
            end
        end
        expected_points.push_back(w);
    endfunction

    function void check_points(raster_word_t got);
        raster_word_t want;
        if (expected_points.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("point word with no step pending: valid=%0d done=%0d",
                         got[ValidF], got[DoneF]);
            return;
        end
        want = expected_points.pop_front();
        for (int i = 0; i < 10; i++)
        begin
            if (got[i] !== want[i])
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%s mismatch: expected %0d, got %0d",
                             field_names[i], $signed(want[i]), $signed(got[i]));
            end
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 600000;
    localparam int SettleCycles = 16;
    localparam int HoldCycles   = 400;
    localparam int RandomSteps  = 900;

    logic        clk;
    logic        rst_n;
    bit          tx_steady;
    bit          rx_steady;
    bit          rx_hold;
    int unsigned cycle_count;

    elr_req_if step_ch();
    elr_rsp_if point_ch();
    elr_cfg_if cfg_ch();

    ellipse_walk_checker walk_chk = new();

    ellipse_region1_rasterizer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (step_ch),
        .rsp   (point_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL ellipse_region1_rasterizer_core");
        $finish;
    end

    task automatic send_step(input bit restart);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            step_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_ch.valid   <= 1'b1;
        step_ch.restart <= restart;
        do @(posedge clk); while (step_ch.ready !== 1'b1);
        walk_chk.predict_step(restart);
    endtask

    task automatic write_reg(input logic [elr_pkg::IdxW-1:0] idx, input logic [9:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        walk_chk.set_reg(idx, val);
    endtask

    // block may still be updating y after the last word leaves
    task automatic wait_drained();
        while (walk_chk.outstanding() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [9:0] pick_center();
        case ($urandom_range(0, 3))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [9:0] pick_axis();
        logic [8:0] v;
        if ($urandom_range(0, 3) == 0)
            v = 9'($urandom_range(0, 511));
        else if ($urandom_range(0, 7) == 0)
            v = $urandom_range(0, 1) ? 9'd511 : 9'd0;
        else
            v = 9'($urandom_range(0, 31));
        return {1'($urandom_range(0, 1)), v};
    endfunction

    // receive side
    initial
    begin
        int           stall;
        raster_word_t got;
        point_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                point_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else if (!rx_steady)
            begin
                stall = $urandom_range(0, 11);
                if (stall > 0)
                begin
                    point_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            point_ch.ready <= 1'b1;
            do @(posedge clk); while (point_ch.valid !== 1'b1);
            got[0] = point_ch.q1_x;
            got[1] = point_ch.q1_y;
            got[2] = point_ch.q4_x;
            got[3] = point_ch.q4_y;
            got[4] = point_ch.q3_x;
            got[5] = point_ch.q3_y;
            got[6] = point_ch.q2_x;
            got[7] = point_ch.q2_y;
            got[8] = {11'd0, point_ch.point_valid};
            got[9] = {11'd0, point_ch.done_res};
            walk_chk.check_points(got);
        end
    end

    initial
    begin
        int  n;
        int  phase;
        int  stepped;
        bit  sat;
        bit  restart;
        rst_n           = 1'b0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        rx_hold         = 1'b0;
        step_ch.valid   <= 1'b0;
        step_ch.restart <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= elr_pkg::REG_CENTER_X;
        cfg_ch.data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle after reset
        send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        // tiny ellipse at the corner: negative x, y past 1023
        write_reg(elr_pkg::REG_CENTER_X, 10'd0);
        write_reg(elr_pkg::REG_CENTER_Y, 10'd1023);
        write_reg(elr_pkg::REG_SEMI_AXIS_A, 10'd3);
        write_reg(elr_pkg::REG_SEMI_AXIS_B, 10'd2);
        cfg_ch.valid <= 1'b0;
        send_step(1'b1);
        repeat (4) send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        // largest axes, upper bit of axis data ignored
        write_reg(elr_pkg::REG_CENTER_X, 10'd1023);
        write_reg(elr_pkg::REG_CENTER_Y, 10'd0);
        write_reg(elr_pkg::REG_SEMI_AXIS_A, 10'h3FF);
        write_reg(elr_pkg::REG_SEMI_AXIS_B, 10'h1FF);
        cfg_ch.valid <= 1'b0;
        send_step(1'b1);
        repeat (3) send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        // change mid-walk: a = 0 ends it at once
        write_reg(elr_pkg::REG_CENTER_X, 10'd512);
        write_reg(elr_pkg::REG_SEMI_AXIS_A, 10'd0);
        cfg_ch.valid <= 1'b0;
        repeat (2) send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        write_reg(elr_pkg::REG_SEMI_AXIS_B, 10'd7);
        cfg_ch.valid <= 1'b0;
        send_step(1'b1);
        repeat (2) send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        // restart while walking
        write_reg(elr_pkg::REG_SEMI_AXIS_A, 10'd20);
        write_reg(elr_pkg::REG_SEMI_AXIS_B, 10'd10);
        cfg_ch.valid <= 1'b0;
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        step_ch.valid <= 1'b0;
        wait_drained();

        phase   = 0;
        stepped = 0;
        while (stepped < RandomSteps)
        begin
            sat = (phase == 6);
            if ($urandom_range(0, 1))
                write_reg(elr_pkg::REG_CENTER_X, pick_center());
            if ($urandom_range(0, 1))
                write_reg(elr_pkg::REG_CENTER_Y, pick_center());
            if ($urandom_range(0, 1))
                write_reg(elr_pkg::REG_SEMI_AXIS_A, pick_axis());
            if (sat)
                write_reg(elr_pkg::REG_SEMI_AXIS_B, 10'd0);
            else if ($urandom_range(0, 1))
                write_reg(elr_pkg::REG_SEMI_AXIS_B, pick_axis());
            cfg_ch.valid <= 1'b0;

            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            n = $urandom_range(4, 48);
            if (phase == 3)
            begin
                rx_hold   = 1'b1;
                tx_steady = 1'b1;
                n         = 40;
            end
            // b = 0: x runs to its limit before region one ends
            if (sat)
                n = 1026;

            for (int i = 0; i < n; i++)
            begin
                if (i == 0)
                    restart = sat || ($urandom_range(0, 9) != 0);
                else
                    restart = !sat && ($urandom_range(0, 29) == 0);
                send_step(restart);
            end
            step_ch.valid <= 1'b0;
            wait_drained();
            stepped += n;
            phase++;
        end

        if (walk_chk.error_count == 0 && walk_chk.outstanding() == 0)
            $display("PASS ellipse_region1_rasterizer_core");
        else
            $display("FAIL ellipse_region1_rasterizer_core");
        $finish;
    end
endmodule

`default_nettype wire
